[rtl/scp_pkg.sv]
package scp_pkg;

  // Function select codes
  localparam logic MODE_SINE   = 1'b0;
  localparam logic MODE_COSINE = 1'b1;

  // Polynomial: eight Q2.30 coefficients, highest power first
  localparam int N_TERMS    = 8;
  localparam int NUM_STEPS  = N_TERMS - 1;
  localparam int TERM_IDX_W = $clog2(N_TERMS);
  localparam int COEF_WIDTH = 32;
  // Horner accumulator, Q2.30 with headroom for the partial sums
  localparam int ACC_WIDTH  = 34;
  localparam int COEF_FRAC  = 30;

  // pi and two pi in Q2.30
  localparam longint PI_Q30     = 64'sd3373259426;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;

  localparam logic signed [COEF_WIDTH-1:0] SIN_COEF [N_TERMS] = '{
    -32'sd206451, -32'sd37, 32'sd8942932, 32'sd31,
    -32'sd178955611, -32'sd6, 32'sd1073741727, 32'sd0
  };

  localparam logic signed [COEF_WIDTH-1:0] COS_COEF [N_TERMS] = '{
    32'sd94434, -32'sd1537823, -32'sd157590, 32'sd44869272,
    32'sd79449, -32'sd536932072, -32'sd12006, 32'sd1073745689
  };

  // Coefficient of Horner step idx for the selected function
  function automatic logic signed [COEF_WIDTH-1:0] coef_at(input logic mode,
                                                          input logic [TERM_IDX_W-1:0] idx);
    logic signed [COEF_WIDTH-1:0] c;
    if (mode == MODE_COSINE) begin
      c = COS_COEF[idx];
    end else begin
      c = SIN_COEF[idx];
    end
    return c;
  endfunction

endpackage

[rtl/scp_in_if.sv]
interface scp_in_if #(
  parameter int ANGLE_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, output mode, output angle, input ready);
  modport sink   (input valid, input mode, input angle, output ready);
endinterface

[rtl/scp_out_if.sv]
interface scp_out_if #(
  parameter int RESULT_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [RESULT_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/sine_cosine_polynomial_unit.sv]
// Sine or cosine of a Q4.(ANGLE_WIDTH-4) angle in radians, returned in Q2.(RESULT_WIDTH-2)
// and saturated to plus or minus one. The angle is wrapped once by two pi into [-pi, pi],
// then a degree-7 polynomial is evaluated by Horner's rule with Q2.30 coefficients. The unit
// takes one beat per cycle while the output is ready or any stage is empty, and returns each
// result through sixteen register stages: one wrap stage, seven Horner steps of two stages
// each (a product register, then round and add the next coefficient), and a round-and-clamp
// output register. Stages advance on their own, so a stall at the output is absorbed by
// empty stages before it reaches the input. The interface instances must carry the same width
// parameters as this module.
module sine_cosine_polynomial_unit import scp_pkg::*; #(
  parameter int ANGLE_WIDTH  = 16,
  parameter int RESULT_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  scp_in_if.sink    sample_i,
  scp_out_if.source result_o
);

  localparam int AW         = ANGLE_WIDTH;
  localparam int RW         = RESULT_WIDTH;
  localparam int AFRAC      = AW - 4;
  localparam int AXW        = AW + 1;
  localparam int PW         = ACC_WIDTH + AW;
  localparam int RSW        = ACC_WIDTH + 1;
  localparam int NUM_STAGES = 2 * NUM_STEPS + 2;
  localparam int OUT_STAGE  = NUM_STAGES - 1;

  // Angle-format pi and two pi, rounded half up from Q2.30
  localparam int     ASHIFT    = COEF_FRAC - AFRAC;
  localparam longint PI_A_L    = (PI_Q30 + (longint'(1) << (ASHIFT - 1))) >>> ASHIFT;
  localparam longint TWO_PI_A_L = (TWO_PI_Q30 + (longint'(1) << (ASHIFT - 1))) >>> ASHIFT;
  localparam logic signed [AXW-1:0] PI_A     = AXW'(PI_A_L);
  localparam logic signed [AXW-1:0] TWO_PI_A = AXW'(TWO_PI_A_L);

  // Rounding constants for the product and for the result
  localparam logic signed [PW-1:0] HALF_A = PW'(longint'(1) << (AFRAC - 1));
  localparam int     RSHIFT   = COEF_FRAC - (RW - 2);
  localparam longint HALF_R_L = (RSHIFT == 0) ? longint'(0) : (longint'(1) << (RSHIFT - 1));
  localparam logic signed [RSW-1:0] HALF_R  = RSW'(HALF_R_L);
  localparam logic signed [RSW-1:0] ONE_R   = RSW'(longint'(1) << (RW - 2));

  // Stage valid bits and per-stage advance enables
  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] en;

  // Stage payload
  logic signed [AW-1:0]        x_a_q    [0:NUM_STEPS-1];
  logic                        mode_a_q [0:NUM_STEPS-1];
  logic signed [ACC_WIDTH-1:0] acc_q    [0:NUM_STEPS];
  logic signed [PW-1:0]        prod_q   [1:NUM_STEPS];
  logic                        mode_m_q [1:NUM_STEPS];
  logic signed [AW-1:0]        x_m_q    [1:NUM_STEPS-1];
  logic signed [RW-1:0]        value_q;

  // A stage may load when it or any stage after it is empty, or the output drains
  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      en[i] = result_o.ready ||
              !(&(valid_q | ((NUM_STAGES'(1) << i) - NUM_STAGES'(1))));
    end
  end

  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (en[i]) begin
        valid_d[i] = (i == 0) ? sample_i.valid : valid_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign sample_i.ready = en[0];

  // Wrap the angle once into [-pi, pi] and load the leading coefficient
  logic signed [AXW-1:0] ang_ext;
  logic signed [AXW-1:0] ang_wrap;

  always_comb begin
    ang_ext = AXW'(sample_i.angle);
    if (ang_ext < -PI_A) begin
      ang_wrap = ang_ext + TWO_PI_A;
    end else if (ang_ext > PI_A) begin
      ang_wrap = ang_ext - TWO_PI_A;
    end else begin
      ang_wrap = ang_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_a_q[0]    <= ang_wrap[AW-1:0];
      mode_a_q[0] <= sample_i.mode;
      acc_q[0]    <= ACC_WIDTH'(coef_at(sample_i.mode, TERM_IDX_W'(0)));
    end
  end

  // Horner steps: multiply, then round and add the next coefficient
  for (genvar k = 1; k <= NUM_STEPS; k++) begin : g_step
    logic signed [PW-1:0]        prod_d;
    logic signed [PW-1:0]        prod_rnd;
    logic signed [ACC_WIDTH-1:0] acc_d;

    assign prod_d = PW'(acc_q[k-1]) * PW'(x_a_q[k-1]);

    always_ff @(posedge clk_i) begin
      if (en[2*k-1]) begin
        prod_q[k]   <= prod_d;
        mode_m_q[k] <= mode_a_q[k-1];
      end
    end

    always_comb begin
      prod_rnd = (prod_q[k] + HALF_A) >>> AFRAC;
      acc_d    = ACC_WIDTH'(prod_rnd) + ACC_WIDTH'(coef_at(mode_m_q[k], TERM_IDX_W'(k)));
    end

    always_ff @(posedge clk_i) begin
      if (en[2*k]) begin
        acc_q[k] <= acc_d;
      end
    end

    // Carry the angle and select onward while further steps need them
    if (k < NUM_STEPS) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en[2*k-1]) begin
          x_m_q[k] <= x_a_q[k-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en[2*k]) begin
          x_a_q[k]    <= x_m_q[k];
          mode_a_q[k] <= mode_m_q[k];
        end
      end
    end
  end

  // Round to the result format and clamp to plus or minus one
  logic signed [RSW-1:0] res_rnd;
  logic signed [RSW-1:0] res_sat;

  always_comb begin
    res_rnd = (RSW'(acc_q[NUM_STEPS]) + HALF_R) >>> RSHIFT;
    if (res_rnd > ONE_R) begin
      res_sat = ONE_R;
    end else if (res_rnd < -ONE_R) begin
      res_sat = -ONE_R;
    end else begin
      res_sat = res_rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OUT_STAGE]) begin
      value_q <= res_sat[RW-1:0];
    end
  end

  assign result_o.valid = valid_q[OUT_STAGE];
  assign result_o.value = value_q;

  // A taken beat always lands in the wrap stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.valid && sample_i.ready |=> valid_q[0])
    else $error("accepted beat lost at the wrap stage");

  // Back-pressure reaches the input only when every stage is full and the output stalls
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> (&valid_q) && result_o.valid && !result_o.ready)
    else $error("input stalled while the pipeline has room");

  // A delivered result never exceeds one in magnitude
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (RSW'(result_o.value) <= ONE_R) && (RSW'(result_o.value) >= -ONE_R))
    else $error("result outside plus or minus one");

endmodule
